@@ rtl/etf_pkg.sv @@
// ----------------------------------------------------------------------------
// etf_pkg: shared types, constants and fixed-point helpers
// Word format, register map, sequencer states and saturating arithmetic
// used by the escape-time fractal iterator core and its coordinate mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package etf_pkg;

   localparam int FRAC_BITS    = 28;
   localparam int COUNT_BITS   = 16;
   localparam int WORD_BITS    = FRAC_BITS + 4;
   localparam int PROD_BITS    = 2 * WORD_BITS;
   localparam int PRODQ_BITS   = PROD_BITS - FRAC_BITS;
   localparam int ITER_BITS    = 16;
   localparam int CNT_BITS     = (COUNT_BITS > ITER_BITS) ? COUNT_BITS : ITER_BITS + 1;

   localparam int PIX_BITS     = 12;
   localparam int OFFSET_BITS  = 25;
   localparam int ZOOM_BITS    = 24;
   localparam int RAW_BITS     = 32;
   localparam int VARIANT_BITS = 2;

   localparam int NUM_BITS      = OFFSET_BITS + 1;
   localparam int NUM_MAG_BITS  = OFFSET_BITS;
   localparam int DIVISOR_BITS  = ZOOM_BITS + 3;
   localparam int DIV_STEPS     = WORD_BITS - 1;
   localparam int DIV_STEP_BITS = $clog2(DIV_STEPS);
   localparam int WIDE_BITS     = ((WORD_BITS > RAW_BITS) ? WORD_BITS : RAW_BITS) + 1;

   localparam int ADDR_BITS    = 5;
   localparam int DATA_BITS    = 32;
   localparam int REG_IDX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0]  word_type;
   typedef logic        [WORD_BITS-1:0]  mag_type;
   typedef logic        [PROD_BITS-1:0]  prod_type;
   typedef logic        [PRODQ_BITS-1:0] prodq_type;
   typedef logic        [CNT_BITS-1:0]   count_type;
   typedef logic        [VARIANT_BITS-1:0] variant_type;
   typedef logic        [REG_IDX_BITS-1:0] reg_idx_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam mag_type  MAG_HALF = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS:0] ESCAPE_LIMIT =
      (WORD_BITS+1)'({3'b100, {FRAC_BITS{1'b0}}});

   localparam variant_type VAR_JULIA      = 2'd0;
   localparam variant_type VAR_MANDELBROT = 2'd1;
   localparam variant_type VAR_MANDELBAR  = 2'd2;
   localparam variant_type VAR_BURNING    = 2'd3;

   localparam reg_idx_type REG_VARIANT     = 3'd0;
   localparam reg_idx_type REG_ZOOM        = 3'd1;
   localparam reg_idx_type REG_OFFSET_X    = 3'd2;
   localparam reg_idx_type REG_OFFSET_Y    = 3'd3;
   localparam reg_idx_type REG_JULIA_RE    = 3'd4;
   localparam reg_idx_type REG_JULIA_IM    = 3'd5;
   localparam reg_idx_type REG_MAX_ITER    = 3'd6;
   localparam reg_idx_type REG_COUNT_START = 3'd7;

   localparam logic [ZOOM_BITS-1:0] ZOOM_RESET     = ZOOM_BITS'(300);
   localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(50);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAPX_GO,
      ST_MAPX_WAIT,
      ST_MAPY_GO,
      ST_MAPY_WAIT,
      ST_MUL_RE,
      ST_MUL_IM,
      ST_MUL_CROSS,
      ST_TEST,
      ST_UPDATE
   } state_type;

   function automatic word_type sat_add(word_type a, word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] && !s[WORD_BITS-1]) begin
         return WORD_MIN;
      end else if (!s[WORD_BITS] && s[WORD_BITS-1]) begin
         return WORD_MAX;
      end
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] && !s[WORD_BITS-1]) begin
         return WORD_MIN;
      end else if (!s[WORD_BITS] && s[WORD_BITS-1]) begin
         return WORD_MAX;
      end
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   function automatic word_type sat_neg(word_type a);
      return (a == WORD_MIN) ? WORD_MAX : word_type'(-a);
   endfunction

   function automatic mag_type mag_of(word_type a);
      return a[WORD_BITS-1] ? mag_type'(-a) : mag_type'(a);
   endfunction

   // magnitude after a saturating absolute value
   function automatic mag_type abs_mag(word_type a);
      return (a == WORD_MIN) ? mag_type'(WORD_MAX) : mag_of(a);
   endfunction

   function automatic word_type prod_to_word(logic neg, prod_type p);
      prodq_type m;
      m = p[PROD_BITS-1:FRAC_BITS];
      if (neg) begin
         if (m > prodq_type'(MAG_HALF)) begin
            return WORD_MIN;
         end
         return word_type'(mag_type'(0) - m[WORD_BITS-1:0]);
      end
      if (m > prodq_type'(WORD_MAX)) begin
         return WORD_MAX;
      end
      return word_type'(m[WORD_BITS-1:0]);
   endfunction

   function automatic word_type raw_to_word(logic signed [RAW_BITS-1:0] raw);
      logic signed [WIDE_BITS-1:0] v;
      v = WIDE_BITS'(raw);
      if (v > WIDE_BITS'(WORD_MAX)) begin
         return WORD_MAX;
      end else if (v < WIDE_BITS'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return word_type'(v);
   endfunction

endpackage

`default_nettype wire

@@ rtl/etf_map_div.sv @@
// ----------------------------------------------------------------------------
// etf_map_div: pixel to complex-plane coordinate mapper
// Radix-2 restoring divider, one quotient bit per cycle, computing
// (pixel + offset) * 2^FRAC_BITS / zoom truncated toward zero, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_map_div (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic        [etf_pkg::PIX_BITS-1:0]    pixel,
   input  wire logic signed [etf_pkg::OFFSET_BITS-1:0] offset,
   input  wire logic        [etf_pkg::ZOOM_BITS-1:0]   zoom,
   output      logic                                   done,
   output      etf_pkg::word_type                      coord
);

   logic signed [etf_pkg::NUM_BITS-1:0]     num;
   logic        [etf_pkg::NUM_MAG_BITS-1:0] num_mag;
   logic        [etf_pkg::ZOOM_BITS-1:0]    zoom_eff;
   logic        [etf_pkg::DIVISOR_BITS-1:0] divisor;
   logic                                    over;
   logic        [etf_pkg::DIVISOR_BITS:0]   trial;
   logic                                    fits;

   logic                                    run_ff, run_in;
   logic                                    done_ff, done_in;
   logic        [etf_pkg::DIV_STEP_BITS-1:0] step_ff, step_in;
   logic        [etf_pkg::DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic        [etf_pkg::DIVISOR_BITS-1:0] dvs_ff, dvs_in;
   logic        [etf_pkg::DIV_STEPS-1:0]    q_ff, q_in;
   logic                                    neg_ff, neg_in;
   logic                                    sat_ff, sat_in;

   assign num      = etf_pkg::NUM_BITS'($signed({1'b0, pixel})) +
                     etf_pkg::NUM_BITS'(offset);
   assign num_mag  = num[etf_pkg::NUM_BITS-1] ? etf_pkg::NUM_MAG_BITS'(-num) :
                                                etf_pkg::NUM_MAG_BITS'(num);
   assign zoom_eff = (zoom == '0) ? etf_pkg::ZOOM_BITS'(1) : zoom;
   assign divisor  = {zoom_eff, 3'b000};
   assign over     = etf_pkg::DIVISOR_BITS'(num_mag) >= divisor;

   assign trial = {rem_ff, 1'b0};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      if (start) begin
         rem_in  = etf_pkg::DIVISOR_BITS'(num_mag);
         dvs_in  = divisor;
         q_in    = '0;
         neg_in  = num[etf_pkg::NUM_BITS-1];
         sat_in  = over;
         step_in = '0;
         run_in  = !over;
         done_in = over;
      end else if (run_ff) begin
         rem_in  = fits ? etf_pkg::DIVISOR_BITS'(trial - {1'b0, dvs_ff}) :
                          etf_pkg::DIVISOR_BITS'(trial);
         q_in    = {q_ff[etf_pkg::DIV_STEPS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == etf_pkg::DIV_STEP_BITS'(etf_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      if (sat_ff) begin
         coord = neg_ff ? etf_pkg::WORD_MIN : etf_pkg::WORD_MAX;
      end else if (neg_ff) begin
         coord = etf_pkg::word_type'(etf_pkg::mag_type'(0) - {1'b0, q_ff});
      end else begin
         coord = etf_pkg::word_type'({1'b0, q_ff});
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ rtl/escape_time_fractal_iterator_core.sv @@
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_core: escape-time fractal iterator
// Maps a pixel to the complex plane and iterates a Julia, Mandelbrot,
// Mandelbar or Burning Ship step on one shared multiplier until escape or the limit.
//
//   channel   | ports                                  | transaction
//   ----------+----------------------------------------+-------------------------
//   request   | start, busy, req_*                     | start high, busy low
//   response  | rsp_valid, rsp_iteration_count         | rsp_valid, one cycle
//   config    | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite
//             | prdata, pready                         | (pready tied high)
//
// One request runs two divider passes, each cut short when its coordinate
// saturates, then N escape tests, each after the three products, N between 1 and
// max(1, max_iterations - count_start). The shared 32x32 multiplier, three
// products per pass, sets the loop time. A max_iterations of zero answers in
// the next cycle and busy stays low. Reset is synchronous and loads the
// register defaults. The response is a one-cycle strobe; it is never stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_iterator_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output      logic                                  busy,
   input  wire logic        [etf_pkg::PIX_BITS-1:0]   req_pixel_x,
   input  wire logic        [etf_pkg::PIX_BITS-1:0]   req_pixel_y,
   input  wire logic signed [etf_pkg::RAW_BITS-1:0]   req_start_re,
   input  wire logic signed [etf_pkg::RAW_BITS-1:0]   req_start_im,
   output      logic                                  rsp_valid,
   output      logic        [etf_pkg::COUNT_BITS-1:0] rsp_iteration_count,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic        [etf_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic        [etf_pkg::DATA_BITS-1:0]  pwdata,
   output      logic        [etf_pkg::DATA_BITS-1:0]  prdata,
   output      logic                                  pready
);

   // configuration registers
   etf_pkg::variant_type                      variant_ff, variant_in;
   logic        [etf_pkg::ZOOM_BITS-1:0]      zoom_ff, zoom_in;
   logic signed [etf_pkg::OFFSET_BITS-1:0]    offset_x_ff, offset_x_in;
   logic signed [etf_pkg::OFFSET_BITS-1:0]    offset_y_ff, offset_y_in;
   logic signed [etf_pkg::RAW_BITS-1:0]       julia_re_ff, julia_re_in;
   logic signed [etf_pkg::RAW_BITS-1:0]       julia_im_ff, julia_im_in;
   logic        [etf_pkg::ITER_BITS-1:0]      max_iter_ff, max_iter_in;
   logic        [etf_pkg::ITER_BITS-1:0]      count_start_ff, count_start_in;

   etf_pkg::reg_idx_type                      reg_idx;
   logic                                      csr_write;

   // sequencer
   etf_pkg::state_type                        state_ff, state_in;
   logic                                      div_start;
   logic                                      div_sel_y;
   logic                                      div_done;
   etf_pkg::word_type                         div_coord;

   // request payload
   logic        [etf_pkg::PIX_BITS-1:0]       pix_x_ff, pix_x_in;
   logic        [etf_pkg::PIX_BITS-1:0]       pix_y_ff, pix_y_in;
   logic signed [etf_pkg::RAW_BITS-1:0]       start_re_ff, start_re_in;
   logic signed [etf_pkg::RAW_BITS-1:0]       start_im_ff, start_im_in;

   // iteration datapath
   etf_pkg::word_type                         px_ff, px_in;
   etf_pkg::word_type                         zr_ff, zr_in;
   etf_pkg::word_type                         zi_ff, zi_in;
   etf_pkg::word_type                         cr_ff, cr_in;
   etf_pkg::word_type                         ci_ff, ci_in;
   etf_pkg::word_type                         sr_ff, sr_in;
   etf_pkg::word_type                         si_ff, si_in;
   etf_pkg::word_type                         t_ff, t_in;
   etf_pkg::word_type                         d_ff, d_in;
   etf_pkg::word_type                         tt_ff, tt_in;
   logic                                      t_neg_ff, t_neg_in;
   logic                                      first_ff, first_in;
   etf_pkg::count_type                        cnt_ff, cnt_in;
   etf_pkg::prod_type                         p_ff, p_in;
   etf_pkg::mag_type                          mul_a;
   etf_pkg::mag_type                          mul_b;

   etf_pkg::word_type                         sq;
   etf_pkg::word_type                         sq_dbl;
   etf_pkg::word_type                         t_word;
   etf_pkg::word_type                         t_dbl;
   logic        [etf_pkg::WORD_BITS:0]        mag_sum;
   logic                                      escape;
   etf_pkg::count_type                        cnt_inc;
   logic                                      limit_hit;
   logic                                      finish;
   logic                                      doubling;
   logic                                      adds_c;
   logic                                      zero_limit;

   // response
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic        [etf_pkg::COUNT_BITS-1:0]     rsp_count_ff, rsp_count_in;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   assign reg_idx   = paddr[etf_pkg::ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      variant_in     = variant_ff;
      zoom_in        = zoom_ff;
      offset_x_in    = offset_x_ff;
      offset_y_in    = offset_y_ff;
      julia_re_in    = julia_re_ff;
      julia_im_in    = julia_im_ff;
      max_iter_in    = max_iter_ff;
      count_start_in = count_start_ff;
      if (csr_write) begin
         unique case (reg_idx)
            etf_pkg::REG_VARIANT:     variant_in     = pwdata[etf_pkg::VARIANT_BITS-1:0];
            etf_pkg::REG_ZOOM:        zoom_in        = pwdata[etf_pkg::ZOOM_BITS-1:0];
            etf_pkg::REG_OFFSET_X:    offset_x_in    = pwdata[etf_pkg::OFFSET_BITS-1:0];
            etf_pkg::REG_OFFSET_Y:    offset_y_in    = pwdata[etf_pkg::OFFSET_BITS-1:0];
            etf_pkg::REG_JULIA_RE:    julia_re_in    = pwdata[etf_pkg::RAW_BITS-1:0];
            etf_pkg::REG_JULIA_IM:    julia_im_in    = pwdata[etf_pkg::RAW_BITS-1:0];
            etf_pkg::REG_MAX_ITER:    max_iter_in    = pwdata[etf_pkg::ITER_BITS-1:0];
            etf_pkg::REG_COUNT_START: count_start_in = pwdata[etf_pkg::ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         etf_pkg::REG_VARIANT:     prdata = etf_pkg::DATA_BITS'(variant_ff);
         etf_pkg::REG_ZOOM:        prdata = etf_pkg::DATA_BITS'(zoom_ff);
         etf_pkg::REG_OFFSET_X:    prdata = etf_pkg::DATA_BITS'(offset_x_ff);
         etf_pkg::REG_OFFSET_Y:    prdata = etf_pkg::DATA_BITS'(offset_y_ff);
         etf_pkg::REG_JULIA_RE:    prdata = etf_pkg::DATA_BITS'(julia_re_ff);
         etf_pkg::REG_JULIA_IM:    prdata = etf_pkg::DATA_BITS'(julia_im_ff);
         etf_pkg::REG_MAX_ITER:    prdata = etf_pkg::DATA_BITS'(max_iter_ff);
         etf_pkg::REG_COUNT_START: prdata = etf_pkg::DATA_BITS'(count_start_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff     <= etf_pkg::VAR_MANDELBROT;
         zoom_ff        <= etf_pkg::ZOOM_RESET;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         julia_re_ff    <= '0;
         julia_im_ff    <= '0;
         max_iter_ff    <= etf_pkg::MAX_ITER_RESET;
         count_start_ff <= '0;
      end else begin
         variant_ff     <= variant_in;
         zoom_ff        <= zoom_in;
         offset_x_ff    <= offset_x_in;
         offset_y_ff    <= offset_y_in;
         julia_re_ff    <= julia_re_in;
         julia_im_ff    <= julia_im_in;
         max_iter_ff    <= max_iter_in;
         count_start_ff <= count_start_in;
      end
   end

   // ------------------------------------------------------------------------
   // coordinate mapper, shared by both axes
   // ------------------------------------------------------------------------
   etf_map_div u_map_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .pixel  (div_sel_y ? pix_y_ff : pix_x_ff),
      .offset (div_sel_y ? offset_y_ff : offset_x_ff),
      .zoom   (zoom_ff),
      .done   (div_done),
      .coord  (div_coord)
   );

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   assign zero_limit = (max_iter_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         etf_pkg::ST_IDLE:      if (start && !zero_limit) state_in = etf_pkg::ST_MAPX_GO;
         etf_pkg::ST_MAPX_GO:   state_in = etf_pkg::ST_MAPX_WAIT;
         etf_pkg::ST_MAPX_WAIT: if (div_done) state_in = etf_pkg::ST_MAPY_GO;
         etf_pkg::ST_MAPY_GO:   state_in = etf_pkg::ST_MAPY_WAIT;
         etf_pkg::ST_MAPY_WAIT: if (div_done) state_in = etf_pkg::ST_MUL_RE;
         etf_pkg::ST_MUL_RE:    state_in = etf_pkg::ST_MUL_IM;
         etf_pkg::ST_MUL_IM:    state_in = etf_pkg::ST_MUL_CROSS;
         etf_pkg::ST_MUL_CROSS: state_in = etf_pkg::ST_TEST;
         etf_pkg::ST_TEST:      state_in = finish ? etf_pkg::ST_IDLE : etf_pkg::ST_UPDATE;
         etf_pkg::ST_UPDATE:    state_in = etf_pkg::ST_MUL_RE;
         default:               state_in = etf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = (state_ff == etf_pkg::ST_MAPX_GO) || (state_ff == etf_pkg::ST_MAPY_GO);
      div_sel_y = (state_ff == etf_pkg::ST_MAPY_GO);
      busy      = (state_ff != etf_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // shared multiplier and iteration datapath
   // ------------------------------------------------------------------------
   assign doubling = (variant_ff == etf_pkg::VAR_MANDELBAR) ||
                     (variant_ff == etf_pkg::VAR_BURNING);
   assign adds_c   = (variant_ff == etf_pkg::VAR_JULIA) ||
                     (variant_ff == etf_pkg::VAR_MANDELBROT);

   always_comb begin
      unique case (state_ff)
         etf_pkg::ST_MUL_IM: begin
            mul_a = etf_pkg::mag_of(zi_ff);
            mul_b = etf_pkg::mag_of(zi_ff);
         end
         etf_pkg::ST_MUL_CROSS: begin
            if (variant_ff == etf_pkg::VAR_BURNING) begin
               mul_a = etf_pkg::abs_mag(zi_ff);
               mul_b = etf_pkg::abs_mag(zr_ff);
            end else begin
               mul_a = etf_pkg::mag_of(zi_ff);
               mul_b = etf_pkg::mag_of(zr_ff);
            end
         end
         default: begin
            mul_a = etf_pkg::mag_of(zr_ff);
            mul_b = etf_pkg::mag_of(zr_ff);
         end
      endcase
   end

   assign p_in = etf_pkg::prod_type'(mul_a) * etf_pkg::prod_type'(mul_b);

   assign sq        = etf_pkg::prod_to_word(1'b0, p_ff);
   assign sq_dbl    = (first_ff && doubling) ? etf_pkg::sat_add(sq, sq) : sq;
   assign t_word    = etf_pkg::prod_to_word(t_neg_ff, p_ff);
   assign t_dbl     = etf_pkg::sat_add(t_ff, t_ff);
   assign mag_sum   = {1'b0, sr_ff} + {1'b0, si_ff};
   assign escape    = mag_sum >= etf_pkg::ESCAPE_LIMIT;
   assign cnt_inc   = cnt_ff + 1'b1;
   assign limit_hit = cnt_inc >= etf_pkg::CNT_BITS'(max_iter_ff);
   assign finish    = escape || limit_hit;

   always_comb begin
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      start_re_in  = start_re_ff;
      start_im_in  = start_im_ff;
      px_in        = px_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      tt_in        = tt_ff;
      t_neg_in     = t_neg_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         etf_pkg::ST_IDLE: begin
            if (start) begin
               pix_x_in    = req_pixel_x;
               pix_y_in    = req_pixel_y;
               start_re_in = req_start_re;
               start_im_in = req_start_im;
               if (zero_limit) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
               end
            end
         end
         etf_pkg::ST_MAPX_WAIT: begin
            if (div_done) begin
               px_in = div_coord;
            end
         end
         etf_pkg::ST_MAPY_WAIT: begin
            if (div_done) begin
               if (variant_ff == etf_pkg::VAR_JULIA) begin
                  zr_in = px_ff;
                  zi_in = div_coord;
                  cr_in = etf_pkg::raw_to_word(julia_re_ff);
                  ci_in = etf_pkg::raw_to_word(julia_im_ff);
               end else begin
                  cr_in = px_ff;
                  ci_in = div_coord;
                  zr_in = etf_pkg::raw_to_word(start_re_ff);
                  zi_in = etf_pkg::raw_to_word(start_im_ff);
               end
               cnt_in   = etf_pkg::CNT_BITS'(count_start_ff);
               first_in = 1'b1;
            end
         end
         etf_pkg::ST_MUL_RE: begin
            if (!first_ff) begin
               zi_in = etf_pkg::sat_add(tt_ff, ci_ff);
            end
         end
         etf_pkg::ST_MUL_IM: begin
            sr_in = sq_dbl;
         end
         etf_pkg::ST_MUL_CROSS: begin
            si_in    = sq_dbl;
            t_neg_in = (variant_ff != etf_pkg::VAR_BURNING) &&
                       (zi_ff[etf_pkg::WORD_BITS-1] ^ zr_ff[etf_pkg::WORD_BITS-1]);
         end
         etf_pkg::ST_TEST: begin
            t_in     = t_word;
            d_in     = etf_pkg::sat_sub(sr_ff, si_ff);
            first_in = 1'b0;
            if (!escape) begin
               cnt_in = cnt_inc;
            end
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = escape ? cnt_ff[etf_pkg::COUNT_BITS-1:0] :
                                       cnt_inc[etf_pkg::COUNT_BITS-1:0];
            end
         end
         etf_pkg::ST_UPDATE: begin
            tt_in = (variant_ff == etf_pkg::VAR_MANDELBAR) ? etf_pkg::sat_neg(t_dbl) : t_dbl;
            zr_in = adds_c ? etf_pkg::sat_add(d_ff, cr_ff) : etf_pkg::sat_sub(d_ff, cr_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      start_re_ff  <= start_re_in;
      start_im_ff  <= start_im_in;
      px_ff        <= px_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      sr_ff        <= sr_in;
      si_ff        <= si_in;
      t_ff         <= t_in;
      d_ff         <= d_in;
      tt_ff        <= tt_in;
      t_neg_ff     <= t_neg_in;
      cnt_ff       <= cnt_in;
      p_ff         <= p_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_zero_limit_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && max_iter_ff == '0) |=> (rsp_valid && rsp_iteration_count == '0))
      else $error("zero limit transaction not answered with zero");

   a_squares_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == etf_pkg::ST_TEST) |->
         (!sr_ff[etf_pkg::WORD_BITS-1] && !si_ff[etf_pkg::WORD_BITS-1]))
      else $error("negative square at escape test");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == etf_pkg::ST_MAPX_WAIT || state_ff == etf_pkg::ST_MAPY_WAIT))
      else $error("divider finished outside a wait state");

   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted transaction");
`endif

endmodule

`default_nettype wire
